// ===== src/bmc_pkg.sv =====
// ----------------------------------------------------------------------------
// bmc_pkg
// shared types, codes and helpers for the bank mapper with cycle irq
// ----------------------------------------------------------------------------
`default_nettype none

package bmc_pkg;

   // operation codes of an input word
   localparam logic [1:0] OP_WRITE = 2'd0;
   localparam logic [1:0] OP_READ  = 2'd1;
   localparam logic [1:0] OP_TICK  = 2'd2;
   localparam logic [1:0] OP_NONE  = 2'd3;

   // configuration register indexes
   localparam logic CSR_PRG_LIMIT = 1'b0;
   localparam logic CSR_CHR_LIMIT = 1'b1;

   // decoded write groups, address & 0xF80C
   localparam logic [15:0] ADDR_GROUP_MASK = 16'hF80C;
   localparam logic [15:0] GRP_PRG0        = 16'h8800;
   localparam logic [15:0] GRP_MIRROR      = 16'h9800;
   localparam logic [15:0] GRP_PRG2        = 16'hA000;
   localparam logic [15:0] GRP_PRG1        = 16'hA800;
   localparam logic [15:0] GRP_CNT_LO_A    = 16'hF000;
   localparam logic [15:0] GRP_CNT_LO_B    = 16'hF800;
   localparam logic [15:0] GRP_CNT_HI_A    = 16'hF004;
   localparam logic [15:0] GRP_CNT_HI_B    = 16'hF804;
   localparam logic [15:0] GRP_ENABLE_A    = 16'hF008;
   localparam logic [15:0] GRP_ENABLE_B    = 16'hF808;

   // character bank window and slot offset
   localparam logic [15:0] CHR_WIN_LOW     = 16'hAFFF;
   localparam logic [15:0] CHR_WIN_HIGH    = 16'hF000;
   localparam logic [15:0] CHR_SLOT_OFFSET = 16'h3000;

   // read window 0x6000-0x7fff
   localparam logic [2:0] READ_WIN_TOP = 3'b011;

   typedef struct packed {
      logic       prg0;
      logic       prg1;
      logic       prg2;
      logic       mirror;
      logic       cnt_lo;
      logic       cnt_hi;
      logic       enable;
      logic       chr;
      logic [2:0] chr_slot;
      logic       chr_hi_nibble;
   } bmc_wr_ctrl_type;

   typedef struct packed {
      logic [2:0][7:0] prg;
      logic [1:0]      mirror;
      logic [7:0][7:0] chr;
      logic            irq_level;
   } bmc_view_type;

   // values above the limit are masked by it
   function automatic logic [7:0] limit_bank(input logic [7:0] v, input logic [7:0] lim);
      return (v > lim) ? (v & lim) : v;
   endfunction

endpackage

`default_nettype wire

// ===== src/bmc_decode.sv =====
// ----------------------------------------------------------------------------
// bmc_decode
// write address decode into register group strobes
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_decode
   import bmc_pkg::*;
(
   input  wire logic [15:0]     address,
   output bmc_wr_ctrl_type      ctrl
);

   logic [15:0] grp;
   logic [15:0] diff;

   assign grp  = address & ADDR_GROUP_MASK;
   assign diff = address - CHR_SLOT_OFFSET;

   always_comb begin
      ctrl               = '0;
      ctrl.chr_slot      = diff[13:11] | address[5:3];
      ctrl.chr_hi_nibble = address[2];
      if (grp == GRP_PRG0) begin
         ctrl.prg0 = 1'b1;
      end else if (grp == GRP_MIRROR) begin
         ctrl.mirror = 1'b1;
      end else if (grp == GRP_PRG2) begin
         ctrl.prg2 = 1'b1;
      end else if (grp == GRP_PRG1) begin
         ctrl.prg1 = 1'b1;
      end else if (grp == GRP_CNT_LO_A || grp == GRP_CNT_LO_B) begin
         ctrl.cnt_lo = 1'b1;
      end else if (grp == GRP_CNT_HI_A || grp == GRP_CNT_HI_B) begin
         ctrl.cnt_hi = 1'b1;
      end else if (grp == GRP_ENABLE_A || grp == GRP_ENABLE_B) begin
         ctrl.enable = 1'b1;
      end else if (address > CHR_WIN_LOW && address < CHR_WIN_HIGH) begin
         ctrl.chr = 1'b1;
      end
   end

endmodule

`default_nettype wire

// ===== src/bmc_regs.sv =====
// ----------------------------------------------------------------------------
// bmc_regs
// mapper state: banks, mirroring, irq counter, prescaler and delay
// ----------------------------------------------------------------------------
`default_nettype none

module bmc_regs
   import bmc_pkg::*;
#(
   parameter int PRESCALE_PERIOD = 114
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            fire,
   input  wire logic [1:0]      operation,
   input  wire logic [7:0]      write_data,
   input  bmc_wr_ctrl_type      ctrl,
   input  wire logic [7:0]      prg_limit,
   input  wire logic [7:0]      chr_limit,
   output bmc_view_type         view_in
);

   localparam int PW = $clog2(PRESCALE_PERIOD);

   logic [2:0][7:0] prg_ff, prg_in;
   logic [1:0]      mirror_ff, mirror_in;
   logic [7:0][7:0] chr_ff, chr_in;
   logic [7:0]      count_ff, count_in;
   logic            enable_ff, enable_in;
   logic [PW-1:0]   prescale_ff, prescale_in;
   logic            delay_ff, delay_in;
   logic            level_ff, level_in;

   logic [PW:0]     pre_next;
   logic [7:0]      chr_old;
   logic [7:0]      chr_new;
   logic [7:0]      count_inc;

   assign pre_next  = {1'b0, prescale_ff} + (PW+1)'(1);
   assign chr_old   = chr_ff[ctrl.chr_slot];
   assign chr_new   = ctrl.chr_hi_nibble ? {write_data[3:0], chr_old[3:0]}
                                         : {chr_old[7:4], write_data[3:0]};
   assign count_inc = count_ff + 8'd1;

   always_comb begin
      prg_in      = prg_ff;
      mirror_in   = mirror_ff;
      chr_in      = chr_ff;
      count_in    = count_ff;
      enable_in   = enable_ff;
      prescale_in = prescale_ff;
      delay_in    = delay_ff;
      level_in    = level_ff;
      if (fire) begin
         case (operation)
            OP_WRITE: begin
               if (ctrl.prg0)   prg_in[0] = limit_bank(write_data, prg_limit);
               if (ctrl.prg1)   prg_in[1] = limit_bank(write_data, prg_limit);
               if (ctrl.prg2)   prg_in[2] = limit_bank(write_data, prg_limit);
               if (ctrl.mirror) mirror_in = write_data[1:0];
               if (ctrl.cnt_lo) count_in  = {count_ff[7:4], write_data[3:0]};
               if (ctrl.cnt_hi) count_in  = {write_data[3:0], count_ff[3:0]};
               if (ctrl.enable) begin
                  enable_in = (write_data != 8'd0);
                  // disable clears prescaler and acks, armed delay survives
                  if (write_data == 8'd0) begin
                     prescale_in = '0;
                     level_in    = 1'b0;
                  end
               end
               if (ctrl.chr) chr_in[ctrl.chr_slot] = limit_bank(chr_new, chr_limit);
            end
            OP_TICK: begin
               if (delay_ff) begin
                  delay_in = 1'b0;
                  level_in = 1'b1;
               end
               if (pre_next < (PW+1)'(PRESCALE_PERIOD)) begin
                  prescale_in = pre_next[PW-1:0];
               end else begin
                  prescale_in = '0;
                  if (enable_ff) begin
                     count_in = count_inc;
                     if (count_inc == 8'd0) delay_in = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_ff      <= '0;
         mirror_ff   <= '0;
         for (int i = 0; i < 8; i++) chr_ff[i] <= 8'(i);
         count_ff    <= '0;
         enable_ff   <= 1'b0;
         prescale_ff <= '0;
         delay_ff    <= 1'b0;
         level_ff    <= 1'b0;
      end else begin
         prg_ff      <= prg_in;
         mirror_ff   <= mirror_in;
         chr_ff      <= chr_in;
         count_ff    <= count_in;
         enable_ff   <= enable_in;
         prescale_ff <= prescale_in;
         delay_ff    <= delay_in;
         level_ff    <= level_in;
      end
   end

   always_comb begin
      view_in.prg       = prg_in;
      view_in.mirror    = mirror_in;
      view_in.chr       = chr_in;
      view_in.irq_level = level_in;
   end

endmodule

`default_nettype wire

// ===== src/bank_mapper_with_cycle_irq_top.sv =====
// ----------------------------------------------------------------------------
// bank_mapper_with_cycle_irq_top
// cpu bus bank mapper with prescaled cycle irq, one result word per item
// ----------------------------------------------------------------------------
//
//   channel  dir  handshake           payload
//   req      in   req_valid/ready     operation, address, write_data
//   rsp      out  rsp_valid/ready     read_hit, rom_offset, irq_line, mirror, banks
//   csr      in   csr_wr_en           csr_index, csr_wr_data (no read-back)
//
// one word accepted per clock when the result side keeps up; a word passes the
// input register, then decode/update into the result register
// throughput is set by the state update in the exec stage
// synchronous active-high reset restores the bank and irq state
// a stalled result holds the exec stage; the input register still fills once
// ----------------------------------------------------------------------------
`default_nettype none

module bank_mapper_with_cycle_irq_top
   import bmc_pkg::*;
#(
   parameter int PRESCALE_PERIOD = 114
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // request channel
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [1:0]   req_operation,
   input  wire logic [15:0]  req_address,
   input  wire logic [7:0]   req_write_data,
   // response channel
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_read_hit,
   output logic [12:0]       rsp_rom_offset,
   output logic              rsp_irq_line,
   output logic [1:0]        rsp_mirror_mode,
   output logic [7:0]        rsp_prg_bank_lo,
   output logic [7:0]        rsp_prg_bank_mid,
   output logic [7:0]        rsp_prg_bank_hi,
   output logic [63:0]       rsp_chr_banks_packed,
   // configuration
   input  wire logic         csr_wr_en,
   input  wire logic         csr_index,
   input  wire logic [7:0]   csr_wr_data
);

   // limit registers
   logic [7:0] prg_limit_ff;
   logic [7:0] chr_limit_ff;

   // input register
   logic        in_valid_ff;
   logic [1:0]  in_op_ff;
   logic [15:0] in_addr_ff;
   logic [7:0]  in_data_ff;

   // result register
   logic        out_valid_ff;
   logic        out_hit_ff;
   logic [12:0] out_offset_ff;
   bmc_view_type out_view_ff;

   logic            advance;
   logic            fire;
   logic            read_hit;
   bmc_wr_ctrl_type wr_ctrl;
   bmc_view_type    view_in;

   // exec stage moves when the result register is free or being drained
   assign advance   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   assign read_hit = (in_op_ff == OP_READ) && (in_addr_ff[15:13] == READ_WIN_TOP);

   always_ff @(posedge clock) begin
      if (reset) begin
         prg_limit_ff <= 8'hFF;
         chr_limit_ff <= 8'hFF;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PRG_LIMIT: prg_limit_ff <= csr_wr_data;
            CSR_CHR_LIMIT: chr_limit_ff <= csr_wr_data;
            default: begin
            end
         endcase
      end
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_op_ff   <= req_operation;
         in_addr_ff <= req_address;
         in_data_ff <= req_write_data;
      end
   end

   bmc_decode u_decode (
      .address (in_addr_ff),
      .ctrl    (wr_ctrl)
   );

   bmc_regs #(
      .PRESCALE_PERIOD (PRESCALE_PERIOD)
   ) u_regs (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .operation  (in_op_ff),
      .write_data (in_data_ff),
      .ctrl       (wr_ctrl),
      .prg_limit  (prg_limit_ff),
      .chr_limit  (chr_limit_ff),
      .view_in    (view_in)
   );

   // result stage
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_hit_ff    <= read_hit;
         out_offset_ff <= read_hit ? in_addr_ff[12:0] : 13'd0;
         out_view_ff   <= view_in;
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_read_hit         = out_hit_ff;
   assign rsp_rom_offset       = out_offset_ff;
   assign rsp_irq_line         = out_view_ff.irq_level;
   assign rsp_mirror_mode      = out_view_ff.mirror;
   assign rsp_prg_bank_lo      = out_view_ff.prg[0];
   assign rsp_prg_bank_mid     = out_view_ff.prg[1];
   assign rsp_prg_bank_hi      = out_view_ff.prg[2];
   assign rsp_chr_banks_packed = out_view_ff.chr;

endmodule

`default_nettype wire
